/* hw/rtl/mrrs_pkg.sv */
// Package for the multicore round-robin scheduler: sizes, opcodes and the
// ready-queue command struct. No dependencies; used by every module of the block.
`default_nettype none

package mrrs_pkg;

   localparam int NUM_CORES    = 4;
   localparam int QUEUE_DEPTH  = 16;
   localparam int TASK_ID_BITS = 10;

   // Quantum registers: one per core slot of the register map.
   localparam int NUM_QREGS  = 4;
   localparam int QREG_IDX_W = 2;
   localparam int QUANTUM_W  = 10;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(4);

   // Field widths of the stream payloads.
   localparam int OPCODE_W  = 2;
   localparam int CORE_W    = 2;
   localparam int TASK_W    = 10;
   localparam int SLICE_W   = 10;
   localparam int CSR_IDX_W = 4;

   localparam int CORE_IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int HEAD_W     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_BLOCK = 2'd2,
      OP_EXIT  = 2'd3
   } opcode_type;

   typedef logic [TASK_ID_BITS-1:0] task_id_type;

   typedef struct packed {
      logic pop;
      logic push;
   } queue_cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/multicore_round_robin_scheduler.sv */
// Top level of the multicore round-robin scheduler: input register, scheduling
// decision, per-core state and result register. Depends on mrrs_pkg and mrrs_ready_queue.
//
//   Channel  Direction  Handshake                Payload
//   req_     in         req_tvalid / req_tready  tuser: opcode; tdata: core, task_id
//   rsp_     out        rsp_tvalid / rsp_tready  tdata: next_task; tuser: idle, dropped
//   csr_     in         csr_valid / csr_ready    csr_index, csr_data (quantum per core)
//
// One transaction is taken per clock cycle while rsp_tready is high. The decision is
// made while the transaction sits in the input register and is loaded into the result
// register once that register is free or being emptied. Reset is synchronous and active
// high; it empties the queue, idles every core and sets each quantum to 4. Queue storage
// is not cleared and needs no clearing pass.
// With rsp_tready low the result holds, the input register takes one more
// transaction, and req_tready then drops until the result is taken.
`default_nettype none

module multicore_round_robin_scheduler (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [15:0]                        req_tdata,  // [1:0] core, [11:2] task_id
   input  wire logic [mrrs_pkg::OPCODE_W-1:0]      req_tuser,  // [1:0] opcode
   // Response stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [15:0]                             rsp_tdata,  // [9:0] next_task
   output logic [1:0]                              rsp_tuser,  // [0] next_is_idle, [1] load_dropped
   // Configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mrrs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mrrs_pkg::QUANTUM_W-1:0]     csr_data
);
   import mrrs_pkg::*;

   // Input register
   logic                     s1_valid_ff, s1_valid_in;
   opcode_type               s1_op_ff;
   logic [CORE_W-1:0]        s1_core_ff;
   logic [TASK_W-1:0]        s1_tid_ff;

   // Result register
   logic                     out_valid_ff, out_valid_in;
   logic [TASK_W-1:0]        out_task_ff, out_task_in;
   logic                     out_idle_ff, out_idle_in;
   logic                     out_dropped_ff, out_dropped_in;

   // Scheduler state
   logic [QUANTUM_W-1:0]     quantum_ff [NUM_QREGS];
   logic [SLICE_W-1:0]       slice_ff [NUM_CORES];
   logic [SLICE_W-1:0]       slice_in [NUM_CORES];
   task_id_type              task_ff [NUM_CORES];
   task_id_type              task_in [NUM_CORES];
   logic [NUM_CORES-1:0]     idle_ff, idle_in;

   // Queue interface
   queue_cmd_type            q_cmd;
   task_id_type              q_push_data;
   task_id_type              q_head;
   logic [COUNT_W-1:0]       q_count;

   logic                     advance;
   logic                     core_ok;
   logic [CORE_IDX_W-1:0]    core_idx;
   logic [QUANTUM_W-1:0]     quantum_sel;
   logic [SLICE_W:0]         slice_next;
   logic                     wrap;
   logic                     q_empty;
   logic                     q_full;

   // The decision runs when the input register holds a transaction and the
   // result register is free or being emptied in this cycle.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff   <= opcode_type'(req_tuser);
         s1_core_ff <= req_tdata[1:0];
         s1_tid_ff  <= req_tdata[11:2];
      end
      if (advance) begin
         out_task_ff    <= out_task_in;
         out_idle_ff    <= out_idle_in;
         out_dropped_ff <= out_dropped_in;
      end
   end

   // Quantum registers; an index past the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QREGS; i++) begin
            quantum_ff[i] <= QUANTUM_RESET;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_QREGS))) begin
         quantum_ff[csr_index[QREG_IDX_W-1:0]] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORES; i++) begin
            slice_ff[i] <= '0;
            task_ff[i]  <= '0;
         end
         idle_ff <= '1;
      end else begin
         for (int i = 0; i < NUM_CORES; i++) begin
            slice_ff[i] <= slice_in[i];
            task_ff[i]  <= task_in[i];
         end
         idle_ff <= idle_in;
      end
   end

   mrrs_ready_queue u_ready_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .push_data (q_push_data),
      .head_data (q_head),
      .count     (q_count)
   );

   assign q_empty = (q_count == '0);
   assign q_full  = (q_count >= COUNT_W'(QUEUE_DEPTH));

   // Scheduling decision for the transaction in the input register.
   always_comb begin
      core_ok     = (int'(s1_core_ff) < NUM_CORES) && (int'(s1_core_ff) < NUM_QREGS);
      core_idx    = CORE_IDX_W'(s1_core_ff);
      quantum_sel = quantum_ff[s1_core_ff[QREG_IDX_W-1:0]];
      slice_next  = {1'b0, slice_ff[core_idx]} + 1'b1;
      // Wrap by compare: a quantum of zero behaves as one, and a counter left
      // above a lowered quantum wraps on its next tick.
      wrap        = (slice_next >= {1'b0, quantum_sel});

      for (int i = 0; i < NUM_CORES; i++) begin
         slice_in[i] = slice_ff[i];
         task_in[i]  = task_ff[i];
      end
      idle_in     = idle_ff;
      q_cmd       = '0;
      q_push_data = task_id_type'(s1_tid_ff);

      out_task_in    = '0;
      out_idle_in    = 1'b0;
      out_dropped_in = 1'b0;

      if (advance) begin
         if (s1_op_ff == OP_LOAD) begin
            // A load into a full queue is discarded and flagged.
            out_dropped_in = q_full;
            q_cmd.push     = !q_full;
         end else if (!core_ok) begin
            out_idle_in = 1'b1;
         end else begin
            case (s1_op_ff)
               OP_EXIT: begin
                  slice_in[core_idx] = '0;
                  if (q_empty) begin
                     idle_in[core_idx] = 1'b1;
                     task_in[core_idx] = '0;
                  end else begin
                     q_cmd.pop         = 1'b1;
                     task_in[core_idx] = q_head;
                     idle_in[core_idx] = 1'b0;
                  end
               end
               OP_TICK, OP_BLOCK: begin
                  if (idle_ff[core_idx]) begin
                     // An idle core picks up the head at once; its counter stays.
                     if (!q_empty) begin
                        q_cmd.pop         = 1'b1;
                        task_in[core_idx] = q_head;
                        idle_in[core_idx] = 1'b0;
                     end
                  end else begin
                     slice_in[core_idx] = wrap ? '0 : slice_next[SLICE_W-1:0];
                     // Rotation pops the head and pushes the running task in the
                     // same cycle, so it never overflows the queue.
                     if (wrap && !q_empty) begin
                        q_cmd.pop         = 1'b1;
                        q_cmd.push        = 1'b1;
                        q_push_data       = task_ff[core_idx];
                        task_in[core_idx] = q_head;
                     end
                  end
               end
               default: begin
                  out_idle_in = 1'b1;
               end
            endcase
            out_idle_in = idle_in[core_idx];
            out_task_in = idle_in[core_idx] ? '0 : TASK_W'(task_in[core_idx]);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = 16'(out_task_ff);
   assign rsp_tuser  = {out_dropped_ff, out_idle_ff};

   a_load_not_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dropped_ff) |-> (!out_idle_ff && out_task_ff == '0))
      else $error("dropped load result carries a task or idle flag");

   a_idle_zero_task: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_idle_ff) |-> out_task_ff == '0)
      else $error("idle result carries a nonzero task id");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == OP_LOAD && q_full) |=> (out_valid_ff && out_dropped_ff))
      else $error("load into a full queue was not flagged");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_tid_ff)))
      else $error("input register lost a pending transaction");

endmodule

`default_nettype wire

/* hw/rtl/mrrs_ready_queue.sv */
// Shared ready queue of task ids: a circular register file with head and count.
// Depends on mrrs_pkg for the depth, id width and command struct.
`default_nettype none

module mrrs_ready_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mrrs_pkg::queue_cmd_type cmd,
   input  wire mrrs_pkg::task_id_type  push_data,
   output mrrs_pkg::task_id_type       head_data,
   output logic [mrrs_pkg::COUNT_W-1:0] count
);
   import mrrs_pkg::*;

   localparam int SUM_W = COUNT_W + 1;

   task_id_type               entry_ff [QUEUE_DEPTH];
   logic [HEAD_W-1:0]         head_ff, head_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [SUM_W-1:0]          tail_sum;
   logic [HEAD_W-1:0]         tail;

   // Tail from the old head and count; a pop and push together land in the
   // same slot as a push after the pop would.
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail = HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail = HEAD_W'(tail_sum);
      end

      head_in = head_ff;
      if (cmd.pop) begin
         head_in = (head_ff == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end

      count_in = count_ff;
      if (cmd.push && !cmd.pop) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         entry_ff[tail] <= push_data;
      end
   end

   assign head_data = entry_ff[head_ff];
   assign count     = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("ready queue holds more entries than its depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from an empty ready queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && !cmd.pop) |-> count_ff != COUNT_W'(QUEUE_DEPTH))
      else $error("push into a full ready queue");

endmodule

`default_nettype wire

/* tb/multicore_round_robin_scheduler_tb.sv */
// Self-checking testbench for the multicore round-robin scheduler: a directed table,
// then randomised scheduling traffic over several quantum settings, checked by a predictor.
// Depends on mrrs_pkg and the multicore_round_robin_scheduler RTL.
`default_nettype none

module multicore_round_robin_scheduler_tb;

   import mrrs_pkg::*;

   // Long receiver hold-off, in cycles, used to fill the pipeline and stall the input.
   localparam int LONG_HOLD   = 64;
   // Generous watchdog on the length of a run, in cycles.
   localparam int CYCLE_LIMIT = 100000;
   localparam int PHASE_ITEMS = 145;

   // One scheduling decision as it appears on the response stream.
   typedef struct packed {
      task_id_type next_task;
      logic        idle;
      logic        dropped;
   } decision_type;

   // One row of the directed table. Rows with fixed_want set carry a hand-worked result.
   typedef struct {
      opcode_type       op;
      logic [CORE_W-1:0] core;
      task_id_type      tid;
      bit               fixed_want;
      decision_type     want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic [OPCODE_W-1:0]   req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [QUANTUM_W-1:0]  csr_data   = '0;

   // Shared control between the stimulus and the receiver process.
   bit quiet         = 1'b0;
   bit long_hold_req = 1'b0;

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   decision_type expected_decisions[$];
   stim_row_type directed_rows[$];

   // Predictor state: a private copy of the ready queue, the per-core state and the quanta.
   task_id_type          ready_copy[QUEUE_DEPTH];
   int                   ready_head;
   int                   ready_count;
   logic [SLICE_W-1:0]   slice_copy[NUM_CORES];
   task_id_type          run_task[NUM_CORES];
   logic                 run_idle[NUM_CORES];
   logic [QUANTUM_W-1:0] quantum_copy[NUM_QREGS];

   multicore_round_robin_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [1:0] core, [11:2] task_id
      .req_tuser  (req_tuser),   // [1:0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [9:0] next_task
      .rsp_tuser  (rsp_tuser),   // [0] next_is_idle, [1] load_dropped
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The watchdog ends a run that hangs, whatever the stimulus is doing.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   function automatic void clear_schedule_copy();
      for (int i = 0; i < QUEUE_DEPTH; i++) ready_copy[i] = '0;
      ready_head  = 0;
      ready_count = 0;
      for (int i = 0; i < NUM_CORES; i++) begin
         slice_copy[i] = '0;
         run_task[i]   = '0;
         run_idle[i]   = 1'b1;
      end
      for (int i = 0; i < NUM_QREGS; i++) quantum_copy[i] = QUANTUM_RESET;
   endfunction

   function automatic task_id_type ready_pop();
      task_id_type v;
      v           = ready_copy[ready_head];
      ready_head  = (ready_head + 1) % QUEUE_DEPTH;
      ready_count = ready_count - 1;
      return v;
   endfunction

   function automatic void ready_push(task_id_type v);
      ready_copy[(ready_head + ready_count) % QUEUE_DEPTH] = v;
      ready_count = ready_count + 1;
   endfunction

   // Works out the decision for one accepted transaction and advances the copy of the state.
   function automatic decision_type schedule_step(opcode_type op, logic [CORE_W-1:0] core,
                                                  task_id_type tid);
      decision_type d;
      int           c;
      int           nxt;
      bit           wrap;
      task_id_type  head;
      d = '0;
      c = int'(core);
      if (op == OP_LOAD) begin
         if (ready_count >= QUEUE_DEPTH) d.dropped = 1'b1;
         else ready_push(tid);
         return d;
      end
      if (c >= NUM_CORES || c >= NUM_QREGS) begin
         d.idle = 1'b1;
         return d;
      end
      if (op == OP_EXIT) begin
         slice_copy[c] = '0;
         if (ready_count == 0) begin
            run_idle[c] = 1'b1;
            run_task[c] = '0;
         end else begin
            run_task[c] = ready_pop();
            run_idle[c] = 1'b0;
         end
      end else if (run_idle[c]) begin
         // An idle core picks up the head at once; with nothing waiting it stays idle.
         if (ready_count != 0) begin
            run_task[c] = ready_pop();
            run_idle[c] = 1'b0;
         end
      end else begin
         // Wrap by compare, so a quantum of zero acts as one and a lowered quantum
         // wraps a counter that had already passed it.
         nxt  = int'(slice_copy[c]) + 1;
         wrap = (nxt >= int'(quantum_copy[c]));
         slice_copy[c] = wrap ? '0 : SLICE_W'(nxt);
         if (wrap && ready_count != 0) begin
            head = ready_pop();
            ready_push(run_task[c]);
            run_task[c] = head;
         end
      end
      d.next_task = run_idle[c] ? '0 : run_task[c];
      d.idle      = run_idle[c];
      return d;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offers one scheduling event and, once it is accepted, records the expected decision.
   // A fixed result, where given, stands in for the predicted one.
   task automatic offer_event(opcode_type op, logic [CORE_W-1:0] core, task_id_type tid,
                              bit fixed_want, decision_type want);
      decision_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, tid, core};
      do @(posedge clock); while (!req_tready);
      predicted = schedule_step(op, core, tid);
      expected_decisions.insert(expected_decisions.size(), fixed_want ? want : predicted);
   endtask

   // Lowers the request valid and waits until every outstanding decision has come back
   // and the two-stage pipeline has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one quantum register; the valid is left high for a following write.
   task automatic write_quantum(logic [CSR_IDX_W-1:0] idx, logic [QUANTUM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (int'(idx) < NUM_QREGS) quantum_copy[idx[QREG_IDX_W-1:0]] = value;
   endtask

   // Writes all four quanta and one index beyond the register map, which must be ignored.
   task automatic set_quanta(int q0, int q1, int q2, int q3, int junk_idx);
      write_quantum(CSR_IDX_W'(0), QUANTUM_W'(q0));
      write_quantum(CSR_IDX_W'(1), QUANTUM_W'(q1));
      write_quantum(CSR_IDX_W'(2), QUANTUM_W'(q2));
      write_quantum(CSR_IDX_W'(3), QUANTUM_W'(q3));
      write_quantum(CSR_IDX_W'(junk_idx), QUANTUM_W'($urandom_range(0, 1023)));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random scheduling traffic. The load share decides whether the ready queue tends to
   // run full, hover or drain empty.
   task automatic run_random(int count, int load_pct, bit pause_midway);
      opcode_type op;
      int         r;
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) wait_drained();
         r = $urandom_range(0, 99);
         if (r < load_pct) op = OP_LOAD;
         else begin
            r = $urandom_range(0, 9);
            op = (r < 5) ? OP_TICK : (r < 8) ? OP_BLOCK : OP_EXIT;
         end
         offer_event(op, CORE_W'($urandom_range(0, NUM_CORES - 1)),
                     task_id_type'($urandom_range(0, 1023)), 1'b0, '0);
      end
   endtask

   task automatic add_row(opcode_type op, int core, int tid, bit fixed_want,
                          int want_task, bit want_idle, bit want_drop);
      stim_row_type row;
      row.op         = op;
      row.core       = CORE_W'(core);
      row.tid        = task_id_type'(tid);
      row.fixed_want = fixed_want;
      row.want       = '{next_task: task_id_type'(want_task), idle: want_idle,
                         dropped: want_drop};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // ---------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------

   // The receiver: random short hold-offs, one long hold-off on request, none when quiet.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < LONG_HOLD; i++) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every transaction on the response stream is matched against the oldest expectation.
   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_decisions.size() == 0) begin
            $display("%0t: unexpected decision, next_task %0d idle %0b dropped %0b",
                     $time, rsp_tdata[9:0], rsp_tuser[0], rsp_tuser[1]);
            fail_count = fail_count + 1;
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_tdata[9:0] !== want.next_task) begin
               $display("%0t: next_task expected %0d, got %0d",
                        $time, want.next_task, rsp_tdata[9:0]);
               fail_count = fail_count + 1;
            end
            if (rsp_tuser[0] !== want.idle) begin
               $display("%0t: next_is_idle expected %0b, got %0b",
                        $time, want.idle, rsp_tuser[0]);
               fail_count = fail_count + 1;
            end
            if (rsp_tuser[1] !== want.dropped) begin
               $display("%0t: load_dropped expected %0b, got %0b",
                        $time, want.dropped, rsp_tuser[1]);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------

   initial begin
      clear_schedule_copy();

      // Directed table, run with the reset quanta of four ticks. A tick on an idle core
      // with nothing queued and an exit with nothing queued both leave the core idle.
      add_row(OP_TICK,  0, 0,    1, 0,    1, 0);
      add_row(OP_EXIT,  3, 1023, 1, 0,    1, 0);
      // The largest and smallest task ids; a block on an idle core takes the head.
      add_row(OP_LOAD,  2, 1023, 1, 0,    0, 0);
      add_row(OP_BLOCK, 1, 0,    1, 1023, 0, 0);
      add_row(OP_LOAD,  1, 0,    1, 0,    0, 0);
      // Fill the ready queue to its depth; the next load is dropped and flagged.
      for (int i = 1; i < QUEUE_DEPTH; i++)
         add_row(OP_LOAD, i % NUM_CORES, (i * 341) % 1024, 0, 0, 0, 0);
      add_row(OP_LOAD,  3, 682,  1, 0,    0, 1);
      // Core 1 runs out its slice with the queue full: rotation pops before it pushes,
      // so nothing is lost. The exit then hands core 1 the next waiting task.
      add_row(OP_TICK,  1, 5,    0, 0,    0, 0);
      add_row(OP_TICK,  1, 10,   0, 0,    0, 0);
      add_row(OP_BLOCK, 1, 20,   0, 0,    0, 0);
      add_row(OP_TICK,  1, 40,   0, 0,    0, 0);
      add_row(OP_EXIT,  1, 80,   0, 0,    0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_event(directed_rows[i].op, directed_rows[i].core, directed_rows[i].tid,
                     directed_rows[i].fixed_want, directed_rows[i].want);
      wait_drained();

      // Short quanta, including one; the receiver holds off long enough at the start
      // for the pipeline to fill and the request side to stall.
      set_quanta(1, 2, 3, 5, 15);
      long_hold_req = 1'b1;
      run_random(PHASE_ITEMS, 50, 1'b0);
      wait_drained();

      // The largest quantum and a quantum of zero; the sender pauses halfway until
      // every decision is back. Loads dominate so that the queue runs full.
      set_quanta(1023, 1, 0, 7, 4);
      run_random(PHASE_ITEMS, 70, 1'b1);
      wait_drained();

      // Quantum of core 0 lowered below the count it has built up, and that of core 1
      // raised to the largest. Few loads, so the queue often runs dry.
      set_quanta(2, 1023, 1, 0, $urandom_range(4, 15));
      run_random(PHASE_ITEMS, 35, 1'b0);
      wait_drained();

      set_quanta($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                 $urandom_range(1, 16), $urandom_range(4, 15));
      run_random(PHASE_ITEMS, 55, 1'b0);
      wait_drained();

      // Final stretch at full rate on both sides.
      set_quanta(3, 1, 2, 6, $urandom_range(8, 15));
      quiet = 1'b1;
      run_random(PHASE_ITEMS, 50, 1'b0);
      wait_drained();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* multicore_round_robin_scheduler.f */
hw/rtl/mrrs_pkg.sv
hw/rtl/mrrs_ready_queue.sv
hw/rtl/multicore_round_robin_scheduler.sv
tb/multicore_round_robin_scheduler_tb.sv
